// ===== src/dda_line_rasterizer_defines.svh =====
// Assertion macros used by the checker file of the line rasterizer.
`ifndef DDA_LINE_RASTERIZER_DEFINES_SVH
`define DDA_LINE_RASTERIZER_DEFINES_SVH

// Same-cycle implication, sampled on clk and disabled while rst_n is low.
`define DDA_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk and disabled while rst_n is low.
`define DDA_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/dda_pkg.sv =====
// Shared constants and types of the line rasterizer.
package dda_pkg;

    localparam int REG_BITS       = 13;
    localparam int CFG_INDEX_BITS = 1;

    localparam logic [REG_BITS-1:0] WIDTH_RESET  = 13'd640;
    localparam logic [REG_BITS-1:0] HEIGHT_RESET = 13'd480;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        REG_SURFACE_WIDTH  = 1'b0,
        REG_SURFACE_HEIGHT = 1'b1
    } cfg_reg_t;

    // Control from the sequencer to the divider lanes.
    typedef struct packed {
        logic load;
        logic shift;
    } div_ctrl_t;

endpackage

// ===== src/dda_ifs.sv =====
// Request and pixel channel interfaces of the line rasterizer.
interface dda_req_if #(
    parameter int COORD_BITS = 13,
    parameter int COLOR_BITS = 32
);
    logic                         valid;
    logic                         ready;
    logic                         mode;
    logic signed [COORD_BITS-1:0] start_x;
    logic signed [COORD_BITS-1:0] start_y;
    logic signed [COORD_BITS-1:0] end_x;
    logic signed [COORD_BITS-1:0] end_y;
    logic [COLOR_BITS-1:0]        draw_color;

    modport source (
        output valid, mode, start_x, start_y, end_x, end_y, draw_color,
        input  ready
    );
    modport sink (
        input  valid, mode, start_x, start_y, end_x, end_y, draw_color,
        output ready
    );
endinterface

interface dda_pix_if #(
    parameter int COORD_BITS = 13,
    parameter int COLOR_BITS = 32
);
    logic                         valid;
    logic                         ready;
    logic signed [COORD_BITS-1:0] pixel_x;
    logic signed [COORD_BITS-1:0] pixel_y;
    logic [COLOR_BITS-1:0]        pixel_color;
    logic                         inside_res;
    logic                         final_pixel;

    modport source (
        output valid, pixel_x, pixel_y, pixel_color, inside_res, final_pixel,
        input  ready
    );
    modport sink (
        input  valid, pixel_x, pixel_y, pixel_color, inside_res, final_pixel,
        output ready
    );
endinterface

// ===== src/dda_line_rasterizer.sv =====
// Line rasterizer top level: start items set up a line, tick items emit pixels.
// A tick is answered by a pixel in the output register in the next cycle.
// Throughput: ticks are taken one per cycle while the pixel output keeps draining.
// A start item holds the request side closed while the two bit-serial dividers
// form the axis steps. Reset idles the block and sets the surface to 640 by 480.
module dda_line_rasterizer
    import dda_pkg::*;
#(
    parameter int COORD_BITS = 13,
    parameter int FRAC_BITS  = 20,
    parameter int COLOR_BITS = 32
) (
    input  logic                      clk,
    input  logic                      rst_n,
    dda_req_if.sink                   req,
    dda_pix_if.source                 pix,
    input  logic                      cfg_we,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [REG_BITS-1:0]       cfg_wdata
);

    // Coordinate differences need one more bit than a coordinate. The
    // accumulator keeps two spare integer bits so that the rounding overshoot
    // of the steps never wraps it.
    localparam int MAG_BITS = COORD_BITS + 1;
    localparam int ACC_BITS = COORD_BITS + FRAC_BITS + 2;
    localparam int PIX_BITS = COORD_BITS + 2;
    localparam int CMP_BITS = (PIX_BITS - 1 > REG_BITS) ? PIX_BITS - 1 : REG_BITS;
    localparam int CNT_BITS = $clog2(FRAC_BITS + 1);
    localparam logic [CNT_BITS-1:0] CNT_LAST = CNT_BITS'(FRAC_BITS);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_DIV  = 3'b010,
        S_DRAW = 3'b100
    } state_t;

    // Control state.
    state_t              state_reg, state_next;
    logic [CNT_BITS-1:0] cnt_reg, cnt_next;
    logic                out_valid_reg, out_valid_next;
    logic [REG_BITS-1:0] surf_w_reg, surf_w_next;
    logic [REG_BITS-1:0] surf_h_reg, surf_h_next;

    // Line state and the output register.
    logic signed [ACC_BITS-1:0]   acc_x_reg, acc_x_next;
    logic signed [ACC_BITS-1:0]   acc_y_reg, acc_y_next;
    logic [MAG_BITS-1:0]          left_reg, left_next;
    logic [COLOR_BITS-1:0]        color_reg, color_next;
    logic signed [COORD_BITS-1:0] out_x_reg, out_x_next;
    logic signed [COORD_BITS-1:0] out_y_reg, out_y_next;
    logic [COLOR_BITS-1:0]        out_color_reg, out_color_next;
    logic                         out_inside_reg, out_inside_next;
    logic                         out_final_reg, out_final_next;

    // Start item decode.
    logic signed [MAG_BITS-1:0] dx, dy;
    logic [MAG_BITS-1:0]        abs_dx, abs_dy, span;

    // Divider lanes.
    div_ctrl_t           div_ctrl;
    logic [ACC_BITS-1:0] step_x, step_y;
    logic                cin_x, cin_y;

    // Current pixel position, truncated toward zero.
    logic signed [PIX_BITS-1:0] px, py;
    logic                       pix_inside;

    logic req_acc;
    logic start_acc;
    logic tick_draw;

    function automatic logic signed [PIX_BITS-1:0] trunc_acc(
        input logic signed [ACC_BITS-1:0] acc
    );
        logic signed [PIX_BITS-1:0] flr;
        logic                       adj;
        flr = acc[ACC_BITS-1:FRAC_BITS];
        adj = acc[ACC_BITS-1] & (acc[FRAC_BITS-1:0] != '0);
        return flr + PIX_BITS'(adj);
    endfunction

    function automatic logic axis_inside(
        input logic signed [PIX_BITS-1:0] p,
        input logic [REG_BITS-1:0]        lim
    );
        return ~p[PIX_BITS-1] & (CMP_BITS'(p[PIX_BITS-2:0]) < CMP_BITS'(lim));
    endfunction

    // A request is taken unless the dividers are busy or a finished pixel is
    // still waiting in the output register with no taker this cycle.
    assign req.ready = (state_reg != S_DIV) && (!out_valid_reg || pix.ready);
    assign req_acc   = req.valid && req.ready;
    assign start_acc = req_acc && !req.mode;
    assign tick_draw = req_acc && req.mode && (state_reg == S_DRAW);

    // The step count is the larger absolute axis difference.
    always_comb
    begin
        dx     = MAG_BITS'(req.end_x) - MAG_BITS'(req.start_x);
        dy     = MAG_BITS'(req.end_y) - MAG_BITS'(req.start_y);
        abs_dx = dx[MAG_BITS-1] ? -dx : dx;
        abs_dy = dy[MAG_BITS-1] ? -dy : dy;
        span   = (abs_dx < abs_dy) ? abs_dy : abs_dx;
    end

    assign div_ctrl.load  = start_acc;
    assign div_ctrl.shift = (state_reg == S_DIV);

    dda_step_div #(
        .MAG_BITS  (MAG_BITS),
        .FRAC_BITS (FRAC_BITS),
        .ACC_BITS  (ACC_BITS)
    ) u_div_x (
        .clk      (clk),
        .ctrl     (div_ctrl),
        .mag      (abs_dx),
        .divisor  (span),
        .neg      (dx[MAG_BITS-1]),
        .step_add (step_x),
        .step_cin (cin_x)
    );

    dda_step_div #(
        .MAG_BITS  (MAG_BITS),
        .FRAC_BITS (FRAC_BITS),
        .ACC_BITS  (ACC_BITS)
    ) u_div_y (
        .clk      (clk),
        .ctrl     (div_ctrl),
        .mag      (abs_dy),
        .divisor  (span),
        .neg      (dy[MAG_BITS-1]),
        .step_add (step_y),
        .step_cin (cin_y)
    );

    always_comb
    begin
        px         = trunc_acc(acc_x_reg);
        py         = trunc_acc(acc_y_reg);
        pix_inside = axis_inside(px, surf_w_reg) & axis_inside(py, surf_h_reg);
    end

    // The user must write the configuration only while the block is idle; the block itself does not enforce it.
    always_comb
    begin
        surf_w_next = surf_w_reg;
        surf_h_next = surf_h_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                REG_SURFACE_WIDTH:  surf_w_next = cfg_wdata;
                REG_SURFACE_HEIGHT: surf_h_next = cfg_wdata;
                default:            surf_w_next = surf_w_reg;
            endcase
        end
    end

    // Sequencer and line state. A start always wins over a line in progress,
    // which is simply dropped. A tick while idle is taken and produces nothing.
    always_comb
    begin
        state_next      = state_reg;
        cnt_next        = cnt_reg;
        acc_x_next      = acc_x_reg;
        acc_y_next      = acc_y_reg;
        left_next       = left_reg;
        color_next      = color_reg;
        out_valid_next  = out_valid_reg && !pix.ready;
        out_x_next      = out_x_reg;
        out_y_next      = out_y_reg;
        out_color_next  = out_color_reg;
        out_inside_next = out_inside_reg;
        out_final_next  = out_final_reg;

        case (state_reg)
            S_DIV:
            begin
                cnt_next = cnt_reg + CNT_BITS'(1);
                if (cnt_reg == CNT_LAST)
                begin
                    state_next = S_DRAW;
                end
            end
            S_IDLE, S_DRAW:
            begin
                if (start_acc)
                begin
                    state_next = S_DIV;
                    cnt_next   = '0;
                    acc_x_next = ACC_BITS'(req.start_x) <<< FRAC_BITS;
                    acc_y_next = ACC_BITS'(req.start_y) <<< FRAC_BITS;
                    left_next  = span;
                    color_next = req.draw_color;
                end
                else if (tick_draw)
                begin
                    out_valid_next  = 1'b1;
                    out_x_next      = px[COORD_BITS-1:0];
                    out_y_next      = py[COORD_BITS-1:0];
                    out_color_next  = color_reg;
                    out_inside_next = pix_inside;
                    out_final_next  = (left_reg == '0);
                    acc_x_next      = acc_x_reg + step_x + ACC_BITS'(cin_x);
                    acc_y_next      = acc_y_reg + step_y + ACC_BITS'(cin_y);
                    if (left_reg == '0)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        left_next = left_reg - MAG_BITS'(1);
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
            surf_w_reg    <= WIDTH_RESET;
            surf_h_reg    <= HEIGHT_RESET;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
            surf_w_reg    <= surf_w_next;
            surf_h_reg    <= surf_h_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_x_reg      <= acc_x_next;
        acc_y_reg      <= acc_y_next;
        left_reg       <= left_next;
        color_reg      <= color_next;
        out_x_reg      <= out_x_next;
        out_y_reg      <= out_y_next;
        out_color_reg  <= out_color_next;
        out_inside_reg <= out_inside_next;
        out_final_reg  <= out_final_next;
    end

    assign pix.valid       = out_valid_reg;
    assign pix.pixel_x     = out_x_reg;
    assign pix.pixel_y     = out_y_reg;
    assign pix.pixel_color = out_color_reg;
    assign pix.inside_res  = out_inside_reg;
    assign pix.final_pixel = out_final_reg;

endmodule

// ===== src/dda_step_div.sv =====
// Bit-serial restoring divider that forms one axis step of the line.
module dda_step_div
    import dda_pkg::*;
#(
    parameter int MAG_BITS  = 14,
    parameter int FRAC_BITS = 20,
    parameter int ACC_BITS  = 35
) (
    input  logic                clk,
    input  div_ctrl_t           ctrl,
    input  logic [MAG_BITS-1:0] mag,
    input  logic [MAG_BITS-1:0] divisor,
    input  logic                neg,
    output logic [ACC_BITS-1:0] step_add,
    output logic                step_cin
);

    logic [MAG_BITS-1:0]  rem_reg, rem_next;
    logic [MAG_BITS-1:0]  div_reg;
    logic [FRAC_BITS:0]   quo_reg, quo_next;
    logic                 neg_reg;
    logic [MAG_BITS:0]    diff;
    logic                 quo_bit;
    logic [MAG_BITS-1:0]  part_rem;
    logic [ACC_BITS-1:0]  mag_q;
    logic                 zero_len;
    logic                 round_up;

    // One quotient bit per cycle while ctrl.shift is high; the partial remainder
    // stays below the divisor, so doubling it never overflows.
    always_comb
    begin
        diff     = {1'b0, rem_reg} - {1'b0, div_reg};
        quo_bit  = ~diff[MAG_BITS];
        part_rem = quo_bit ? diff[MAG_BITS-1:0] : rem_reg;
        rem_next = {part_rem[MAG_BITS-2:0], 1'b0};
        quo_next = {quo_reg[FRAC_BITS-1:0], quo_bit};
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            rem_reg <= mag;
            div_reg <= divisor;
            neg_reg <= neg;
            quo_reg <= '0;
        end
        else if (ctrl.shift)
        begin
            rem_reg <= rem_next;
            quo_reg <= quo_next;
        end
    end

    // The magnitude is rounded up when a remainder is left. A negative step is
    // sent as the one's complement with the carry folded into step_cin.
    always_comb
    begin
        mag_q    = ACC_BITS'(quo_reg);
        zero_len = (div_reg == '0);
        round_up = (rem_reg != '0);
        step_add = zero_len ? '0 : (neg_reg ? ~mag_q : mag_q);
        step_cin = ~zero_len & (neg_reg ^ round_up);
    end

endmodule

// ===== src/dda_checker.sv =====
// Port-level checks of the line rasterizer and their binding to the top level.
`include "dda_line_rasterizer_defines.svh"

module dda_checker #(
    parameter int COORD_BITS = 13,
    parameter int COLOR_BITS = 32
) (
    input logic                  clk,
    input logic                  rst_n,
    input logic                  req_valid,
    input logic                  req_ready,
    input logic                  req_mode,
    input logic                  pix_valid,
    input logic                  pix_ready,
    input logic [COORD_BITS-1:0] pix_x,
    input logic [COORD_BITS-1:0] pix_y,
    input logic [COLOR_BITS-1:0] pix_color,
    input logic                  pix_inside,
    input logic                  pix_final
);

    logic                              pix_stall;
    logic                              tick_taken;
    logic                              start_taken;
    logic [2*COORD_BITS+COLOR_BITS+1:0] pix_word;

    assign pix_stall   = pix_valid && !pix_ready;
    assign tick_taken  = req_valid && req_ready && req_mode;
    assign start_taken = req_valid && req_ready && !req_mode;
    assign pix_word    = {pix_x, pix_y, pix_color, pix_inside, pix_final};

    // A stalled pixel stays put until it is taken.
    `DDA_ASSERT_NXT(a_pix_hold, pix_stall, pix_valid && $stable(pix_word), "stalled pixel changed")

    // A new pixel appears only after a tick request was taken.
    `DDA_ASSERT_IMP(a_pix_cause, $rose(pix_valid), $past(tick_taken), "pixel with no tick request")

    // The step division keeps the request side closed right after a start.
    `DDA_ASSERT_NXT(a_start_busy, start_taken, !req_ready, "request taken during step division")

    // No request is taken while a finished pixel waits with no taker.
    `DDA_ASSERT_IMP(a_out_block, pix_stall, !req_ready, "request taken while output is stalled")

endmodule

bind dda_line_rasterizer dda_checker #(
    .COORD_BITS (COORD_BITS),
    .COLOR_BITS (COLOR_BITS)
) u_dda_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .req_valid  (req.valid),
    .req_ready  (req.ready),
    .req_mode   (req.mode),
    .pix_valid  (pix.valid),
    .pix_ready  (pix.ready),
    .pix_x      (pix.pixel_x),
    .pix_y      (pix.pixel_y),
    .pix_color  (pix.pixel_color),
    .pix_inside (pix.inside_res),
    .pix_final  (pix.final_pixel)
);

// ===== dv/dda_line_rasterizer_test.sv =====
// Self-checking testbench of the DDA line rasterizer: directed, sweeps, stalls, random lines.
`timescale 1ns / 100ps

module dda_line_rasterizer_test
    import dda_pkg::*;
();

    localparam int     COORD_BITS    = 13;
    localparam int     FRAC_BITS     = 20;
    localparam int     COLOR_BITS    = 32;
    localparam longint FIX_ONE       = longint'(1) << FRAC_BITS;
    localparam int     COORD_MIN     = -(1 << (COORD_BITS - 1));
    localparam int     COORD_MAX     = (1 << (COORD_BITS - 1)) - 1;
    localparam int     SURFACE_MAX   = 4096;
    // A start request keeps the request side busy while the dividers run, so this
    // many quiet cycles cover any start still in flight.
    localparam int     SETTLE_CYCLES = FRAC_BITS + 8;
    localparam int     RANDOM_ITEMS  = 1450;
    localparam int     LONG_HOLD     = 300;

    localparam logic MODE_START = 1'b0;
    localparam logic MODE_TICK  = 1'b1;

    typedef logic signed [COORD_BITS-1:0] coord_t;
    typedef logic [COLOR_BITS-1:0]        color_t;
    typedef logic [REG_BITS-1:0]          extent_t;

    // One predicted pixel, in the order the block presents the fields.
    typedef struct packed {
        coord_t x;
        coord_t y;
        color_t color;
        logic   in_surface;
        logic   last;
    } pixel_t;

    logic                      clk = 1'b0;
    logic                      rst_n;
    logic                      cfg_we;
    logic [CFG_INDEX_BITS-1:0] cfg_index;
    extent_t                   cfg_wdata;

    dda_req_if #(.COORD_BITS(COORD_BITS), .COLOR_BITS(COLOR_BITS)) req_ch ();
    dda_pix_if #(.COORD_BITS(COORD_BITS), .COLOR_BITS(COLOR_BITS)) pix_ch ();

    dda_line_rasterizer #(
        .COORD_BITS(COORD_BITS),
        .FRAC_BITS (FRAC_BITS),
        .COLOR_BITS(COLOR_BITS)
    ) u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (req_ch),
        .pix      (pix_ch),
        .cfg_we   (cfg_we),
        .cfg_index(cfg_index),
        .cfg_wdata(cfg_wdata)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Line state of the predictor. The accumulators and steps carry FRAC_BITS
    // fraction bits, exactly as the block holds them.
    longint  line_acc_x;
    longint  line_acc_y;
    longint  line_step_x;
    longint  line_step_y;
    longint  pixels_to_go;
    bit      line_drawing;
    color_t  line_color;
    extent_t model_width  = WIDTH_RESET;
    extent_t model_height = HEIGHT_RESET;

    // Pixels predicted from accepted tick requests and not yet seen at the output.
    pixel_t  pending_pixels[$];

    int failures;
    int items_sent;
    int lines_started;
    int pixels_checked;
    int idle_ticks;
    int surface_writes;

    // Pacing controls shared between the test tasks and the two channel drivers.
    bit sender_steady;
    bit sink_steady;
    int sink_hold_request;

    // Per-axis step: the axis difference over the step count, magnitude rounded up
    // so that the last pixel lands exactly on the far endpoint.
    function automatic longint axis_step(longint delta, longint span);
        longint mag;
        if (span == 0)
            return 0;
        mag = ((delta < 0 ? -delta : delta) * FIX_ONE + span - 1) / span;
        return (delta < 0) ? -mag : mag;
    endfunction

    // Advances the predictor by one accepted request. A start request sets up a
    // new line (dropping any line in progress) and yields nothing; a tick yields
    // one pixel while a line is active and is ignored otherwise.
    function automatic void raster_request(logic mode, coord_t sx, coord_t sy,
                                           coord_t ex, coord_t ey, color_t color);
        longint dx;
        longint dy;
        longint adx;
        longint ady;
        longint span;
        longint px;
        longint py;
        pixel_t next_pixel;
        if (mode == MODE_START)
        begin
            dx = longint'(ex) - longint'(sx);
            dy = longint'(ey) - longint'(sy);
            adx = (dx < 0) ? -dx : dx;
            ady = (dy < 0) ? -dy : dy;
            span = (adx < ady) ? ady : adx;
            line_acc_x   = longint'(sx) * FIX_ONE;
            line_acc_y   = longint'(sy) * FIX_ONE;
            line_step_x  = axis_step(dx, span);
            line_step_y  = axis_step(dy, span);
            pixels_to_go = span + 1;
            line_drawing = 1'b1;
            line_color   = color;
            lines_started++;
        end
        else if (line_drawing)
        begin
            // Integer division truncates toward zero, as the pixel coordinates must.
            px = line_acc_x / FIX_ONE;
            py = line_acc_y / FIX_ONE;
            next_pixel.x          = coord_t'(px);
            next_pixel.y          = coord_t'(py);
            next_pixel.color      = line_color;
            next_pixel.in_surface = (px >= 0) && (py >= 0) &&
                                    (px < longint'(model_width)) &&
                                    (py < longint'(model_height));
            next_pixel.last       = (pixels_to_go <= 1);
            pending_pixels.push_back(next_pixel);
            line_acc_x += line_step_x;
            line_acc_y += line_step_y;
            if (next_pixel.last)
            begin
                pixels_to_go = 0;
                line_drawing = 1'b0;
            end
            else
            begin
                pixels_to_go--;
            end
        end
        else
        begin
            idle_ticks++;
        end
    endfunction

    // Compares the pixel taken at this edge with the oldest prediction.
    function automatic void check_pixel();
        pixel_t want;
        if (pending_pixels.size() == 0)
        begin
            $error("pixel (%0d, %0d) came out with no tick request waiting for it",
                   pix_ch.pixel_x, pix_ch.pixel_y);
            failures++;
            return;
        end
        want = pending_pixels.pop_front();
        pixels_checked++;
        if (pix_ch.pixel_x !== want.x)
        begin
            $error("pixel_x: expected %0d, got %0d", want.x, pix_ch.pixel_x);
            failures++;
        end
        if (pix_ch.pixel_y !== want.y)
        begin
            $error("pixel_y: expected %0d, got %0d", want.y, pix_ch.pixel_y);
            failures++;
        end
        if (pix_ch.pixel_color !== want.color)
        begin
            $error("pixel_color: expected %h, got %h", want.color, pix_ch.pixel_color);
            failures++;
        end
        if (pix_ch.inside_res !== want.in_surface)
        begin
            $error("inside_res: expected %b, got %b", want.in_surface, pix_ch.inside_res);
            failures++;
        end
        if (pix_ch.final_pixel !== want.last)
        begin
            $error("final_pixel: expected %b, got %b", want.last, pix_ch.final_pixel);
            failures++;
        end
    endfunction

    // Both channels are observed at the rising edge. Requests are predicted
    // before pixels are checked, so even a pixel that left in the same cycle as
    // its tick would find its prediction waiting.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (req_ch.valid && req_ch.ready)
                raster_request(req_ch.mode, req_ch.start_x, req_ch.start_y,
                               req_ch.end_x, req_ch.end_y, req_ch.draw_color);
            if (pix_ch.valid && pix_ch.ready)
                check_pixel();
        end
    end

    // Wait drawn before each request and after each pixel; it is often none.
    function automatic int idle_draw();
        return ($urandom_range(0, 3) == 0) ? 0 : int'($urandom_range(0, 16));
    endfunction

    // Pixel receiver. It changes ready only at the falling edge. A long hold
    // asked for by a test is counted down here, cycle by cycle.
    initial
    begin
        int stall;
        stall = 0;
        pix_ch.ready = 1'b0;
        wait (rst_n == 1'b1);
        forever
        begin
            @(negedge clk);
            if (sink_hold_request > 0)
            begin
                stall = sink_hold_request;
                sink_hold_request = 0;
            end
            if (stall > 0)
            begin
                pix_ch.ready = 1'b0;
                stall--;
            end
            else
            begin
                pix_ch.ready = 1'b1;
                @(posedge clk);
                if (pix_ch.valid)
                    stall = sink_steady ? 0 : idle_draw();
            end
        end
    end

    // Offers one request from a falling edge and returns at the falling edge
    // after it was taken. Valid stays high into the next request when no gap is drawn.
    task automatic send_request(logic mode, coord_t sx, coord_t sy,
                                coord_t ex, coord_t ey, color_t color);
        int gap;
        gap = sender_steady ? 0 : idle_draw();
        if (gap > 0)
        begin
            req_ch.valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        req_ch.mode       = mode;
        req_ch.start_x    = sx;
        req_ch.start_y    = sy;
        req_ch.end_x      = ex;
        req_ch.end_y      = ey;
        req_ch.draw_color = color;
        req_ch.valid      = 1'b1;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        items_sent++;
        @(negedge clk);
    endtask

    // A tick carries junk in the coordinate and color fields; the block must ignore it.
    task automatic send_tick();
        send_request(MODE_TICK, coord_t'($urandom), coord_t'($urandom),
                     coord_t'($urandom), coord_t'($urandom), color_t'($urandom));
    endtask

    task automatic draw_line(coord_t sx, coord_t sy, coord_t ex, coord_t ey,
                             color_t color, int ticks);
        send_request(MODE_START, sx, sy, ex, ey, color);
        repeat (ticks) send_tick();
    endtask

    // Lets every predicted pixel drain and any start division finish, so the
    // block is idle before the surface registers change.
    task automatic settle_block();
        req_ch.valid = 1'b0;
        while (pending_pixels.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // Writes both surface registers on consecutive edges; only called while idle.
    task automatic set_surface(extent_t w, extent_t h);
        cfg_we    = 1'b1;
        cfg_index = REG_SURFACE_WIDTH;
        cfg_wdata = w;
        @(negedge clk);
        cfg_index = REG_SURFACE_HEIGHT;
        cfg_wdata = h;
        @(negedge clk);
        cfg_we = 1'b0;
        model_width  = w;
        model_height = h;
        surface_writes++;
    endtask

    function automatic coord_t clamp_coord(int v);
        if (v < COORD_MIN)
            return coord_t'(COORD_MIN);
        if (v > COORD_MAX)
            return coord_t'(COORD_MAX);
        return coord_t'(v);
    endfunction

    function automatic int line_span(coord_t sx, coord_t sy, coord_t ex, coord_t ey);
        int adx;
        int ady;
        adx = int'(ex) - int'(sx);
        ady = int'(ey) - int'(sy);
        adx = (adx < 0) ? -adx : adx;
        ady = (ady < 0) ? -ady : ady;
        return (adx < ady) ? ady : adx;
    endfunction

    // A coordinate close to one of the clipping edges of an axis: zero, the
    // surface limit, or the top of the coordinate range.
    function automatic coord_t edge_coord(extent_t limit);
        case ($urandom_range(0, 2))
            0: return clamp_coord(int'(limit) - 3 + int'($urandom_range(0, 5)));
            1: return clamp_coord(int'($urandom_range(0, 5)) - 3);
            default: return clamp_coord(COORD_MAX - int'($urandom_range(0, 3)));
        endcase
    endfunction

    // Where a random line starts: anywhere, near the origin, or near the limit.
    function automatic coord_t anchor_coord(extent_t limit);
        case ($urandom_range(0, 2))
            0: return coord_t'($urandom);
            1: return clamp_coord(int'($urandom_range(0, 48)) - 8);
            default: return clamp_coord(int'(limit) - 6 + int'($urandom_range(0, 12)));
        endcase
    endfunction

    function automatic extent_t random_extent();
        case ($urandom_range(0, 4))
            0: return extent_t'(1);
            1: return extent_t'(SURFACE_MAX);
            2: return extent_t'($urandom_range(1, 64));
            default: return extent_t'($urandom_range(1, SURFACE_MAX));
        endcase
    endfunction

    // Directed lines under the reset surface of 640 by 480.
    task automatic test_directed_lines();
        // A tick with no line set up produces nothing.
        send_tick();
        // Zero-length line: exactly one pixel, then the extra tick is ignored.
        draw_line(5, 7, 5, 7, 32'h0000_0000, 2);
        // Full-range diagonal between the coordinate extremes, cut short after
        // three pixels; the next start request drops it.
        draw_line(coord_t'(COORD_MIN), coord_t'(COORD_MAX), coord_t'(COORD_MAX),
                  coord_t'(COORD_MIN), 32'hFFFF_FFFF, 3);
        // Crosses the right and bottom edges of the reset surface.
        draw_line(638, 478, 641, 481, 32'hA5A5_5A5A, 4);
        // Negative steps, the x step non-integral: small magnitudes truncate toward zero.
        draw_line(0, 0, -3, -7, 32'h1234_5678, 8);
        // Shallow line leaving the surface through the top-left corner.
        draw_line(1, 1, -1, 0, 32'h8000_0001, 3);
        settle_block();
    endtask

    // Several surface sizes, the extremes and a zero-sized axis among them,
    // each with short lines drawn across its clipping edges.
    task automatic test_surface_sweep();
        extent_t w;
        extent_t h;
        coord_t  sx;
        coord_t  sy;
        coord_t  ex;
        coord_t  ey;
        for (int k = 0; k < 8; k++)
        begin
            case (k)
                0: begin w = extent_t'(1); h = extent_t'(1); end
                1: begin w = extent_t'(SURFACE_MAX); h = extent_t'(SURFACE_MAX); end
                2: begin w = extent_t'(0); h = extent_t'(SURFACE_MAX); end
                3: begin w = extent_t'(SURFACE_MAX); h = extent_t'(0); end
                4: begin w = extent_t'(1); h = extent_t'(SURFACE_MAX); end
                5: begin w = extent_t'(SURFACE_MAX); h = extent_t'(1); end
                6: begin w = random_extent(); h = random_extent(); end
                default: begin w = WIDTH_RESET; h = HEIGHT_RESET; end
            endcase
            set_surface(w, h);
            repeat (4)
            begin
                sx = edge_coord(w);
                sy = edge_coord(h);
                ex = clamp_coord(int'(sx) + int'($urandom_range(0, 8)) - 4);
                ey = clamp_coord(int'(sy) + int'($urandom_range(0, 8)) - 4);
                draw_line(sx, sy, ex, ey, color_t'($urandom), line_span(sx, sy, ex, ey) + 1);
            end
            settle_block();
        end
    endtask

    // The receiver holds off for a long stretch while ticks keep coming back to
    // back, so the block fills and must stall its request side without losing pixels.
    task automatic test_output_stall();
        sender_steady = 1'b1;
        send_request(MODE_START, -20, 5, 20, 18, 32'hC0FF_EE00);
        sink_hold_request = LONG_HOLD;
        repeat (41) send_tick();
        settle_block();
        sender_steady = 1'b0;
    endtask

    // Random lines in phases. Each phase picks a surface and pacing; most lines
    // are drawn to their end, some are cut short by the next start, some get
    // extra ticks past the end, and a few requests are plain noise.
    task automatic test_random_lines();
        coord_t sx;
        coord_t sy;
        coord_t ex;
        coord_t ey;
        int     span;
        int     ticks;
        int     reach;
        int     lines_in_phase;
        int     useful;
        lines_in_phase = 0;
        useful = 0;
        while (useful < RANDOM_ITEMS)
        begin
            if (lines_in_phase == 0)
            begin
                settle_block();
                sender_steady = ($urandom_range(0, 3) == 0);
                sink_steady   = ($urandom_range(0, 3) == 0);
                set_surface(random_extent(), random_extent());
                lines_in_phase = $urandom_range(4, 16);
            end
            lines_in_phase--;
            if ($urandom_range(0, 15) == 0)
            begin
                send_request($urandom_range(0, 1) ? MODE_TICK : MODE_START,
                             coord_t'($urandom), coord_t'($urandom), coord_t'($urandom),
                             coord_t'($urandom), color_t'($urandom));
                continue;
            end
            case ($urandom_range(0, 9))
                0:
                begin
                    sx = coord_t'($urandom);
                    sy = coord_t'($urandom);
                    ex = coord_t'($urandom);
                    ey = coord_t'($urandom);
                end
                1:
                begin
                    sx = $urandom_range(0, 1) ? coord_t'(COORD_MIN) : coord_t'(COORD_MAX);
                    sy = $urandom_range(0, 1) ? coord_t'(COORD_MIN) : coord_t'(COORD_MAX);
                    ex = $urandom_range(0, 1) ? coord_t'(COORD_MIN) : coord_t'(COORD_MAX);
                    ey = $urandom_range(0, 1) ? coord_t'(COORD_MIN) : coord_t'(COORD_MAX);
                end
                default:
                begin
                    sx = anchor_coord(model_width);
                    sy = anchor_coord(model_height);
                    reach = ($urandom_range(0, 7) == 0) ? 150 : 12;
                    ex = clamp_coord(int'(sx) + int'($urandom_range(0, 2 * reach)) - reach);
                    ey = clamp_coord(int'(sy) + int'($urandom_range(0, 2 * reach)) - reach);
                end
            endcase
            span = line_span(sx, sy, ex, ey);
            case ($urandom_range(0, 9))
                0: ticks = $urandom_range(0, span);
                1: ticks = span + 1 + int'($urandom_range(1, 3));
                default: ticks = span + 1;
            endcase
            // Very long lines are only started and drawn a little way.
            if (ticks > 200)
                ticks = $urandom_range(1, 24);
            draw_line(sx, sy, ex, ey, color_t'($urandom), ticks);
            useful += 1 + ((ticks < span + 1) ? ticks : span + 1);
        end
        settle_block();
        sender_steady = 1'b0;
        sink_steady   = 1'b0;
    endtask

    initial
    begin
        rst_n             = 1'b0;
        cfg_we            = 1'b0;
        cfg_index         = REG_SURFACE_WIDTH;
        cfg_wdata         = '0;
        req_ch.valid      = 1'b0;
        req_ch.mode       = MODE_TICK;
        req_ch.start_x    = '0;
        req_ch.start_y    = '0;
        req_ch.end_x      = '0;
        req_ch.end_y      = '0;
        req_ch.draw_color = '0;
        repeat (10) @(negedge clk);
        rst_n = 1'b1;
        repeat (2) @(negedge clk);

        test_directed_lines();
        test_surface_sweep();
        test_output_stall();
        test_random_lines();

        $display("Run covered %0d requests: %0d lines started, %0d pixels checked,",
                 items_sent, lines_started, pixels_checked);
        $display("%0d idle ticks; surface size set %0d times, from zero up to %0d per axis.",
                 idle_ticks, surface_writes, SURFACE_MAX);
        if (failures == 0)
            $display("dda_line_rasterizer verification clean");
        else
            $display("dda_line_rasterizer verification failed");
        $finish;
    end

    // A correct run ends well before this bound, even with every wait at its longest.
    initial
    begin
        #2_000_000;
        $display("dda_line_rasterizer verification failed");
        $finish;
    end

endmodule
